FILE: sv/sclm_pkg.sv
`default_nettype none
package sclm_pkg;

   localparam int LINE_CAPACITY = 128;
   localparam int HELD_W        = $clog2(LINE_CAPACITY);
   localparam int WORD_COUNT    = 19;
   localparam int MAX_WORD_LEN  = 7;
   localparam int TEXT_W        = $clog2(MAX_WORD_LEN + 2);
   localparam int INDEX_W       = 5;
   localparam int LEN_OUT_W     = 7;

   localparam logic [7:0] CHAR_LF  = 8'd10;
   localparam logic [7:0] CHAR_CR  = 8'd13;
   localparam logic [7:0] CHAR_NUL = 8'd0;

   localparam logic [WORD_COUNT-1:0] ALL_ALIVE = '1;

   // words are right aligned: char p of a word of length L is at [8*(L-1-p) +: 8]
   localparam logic [WORD_COUNT-1:0][8*MAX_WORD_LEN-1:0] WORD_TEXT = {
      56'("auto,"), 56'("wft,"), 56'("mode,"), 56'("spad,"), 56'("ft,"),
      56'("rr,"), 56'("rb,"), 56'("wi,"), 56'("ri,"), 56'("test"),
      56'("heatmap"), 56'("ram"), 56'("p"), 56'("v"), 56'("clear"),
      56'("e"), 56'("d"), 56'("t"), 56'("s")
   };

   localparam logic [WORD_COUNT-1:0][2:0] WORD_LEN = {
      3'd5, 3'd4, 3'd5, 3'd5, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4,
      3'd7, 3'd3, 3'd1, 3'd1, 3'd5, 3'd1, 3'd1, 3'd1, 3'd1
   };

   // prefix words are indexes 10 to 18
   localparam logic [WORD_COUNT-1:0] WORD_PREFIX = 19'h7FC00;

   typedef struct packed {
      logic               recognised;
      logic [INDEX_W-1:0] index;
   } match_type;

endpackage
`default_nettype wire

FILE: sv/sclm_match.sv
`default_nettype none
module sclm_match
   import sclm_pkg::*;
(
   input  wire logic [WORD_COUNT-1:0] alive,
   input  wire logic [TEXT_W-1:0]     text_len,
   input  wire logic [7:0]            rx_byte,
   output logic [WORD_COUNT-1:0]      alive_upd,
   output match_type                  pick
);

   logic [WORD_COUNT-1:0] ok;

   // candidate update for one text byte
   always_comb begin
      alive_upd = alive;
      for (int i = 0; i < WORD_COUNT; i++) begin
         for (int p = 0; p < int'(WORD_LEN[i]); p++) begin
            if (text_len == TEXT_W'(p) &&
                rx_byte != WORD_TEXT[i][8*(int'(WORD_LEN[i])-1-p) +: 8]) begin
               alive_upd[i] = 1'b0;
            end
         end
      end
   end

   // first surviving entry whose length condition holds
   always_comb begin
      for (int i = 0; i < WORD_COUNT; i++) begin
         if (WORD_PREFIX[i]) begin
            ok[i] = alive[i] && (text_len >= TEXT_W'(WORD_LEN[i]));
         end else begin
            ok[i] = alive[i] && (text_len == TEXT_W'(WORD_LEN[i]));
         end
      end
      pick = '0;
      for (int i = WORD_COUNT - 1; i >= 0; i--) begin
         if (ok[i]) begin
            pick.recognised = 1'b1;
            pick.index      = INDEX_W'(i);
         end
      end
   end

endmodule
`default_nettype wire

FILE: sv/serial_command_line_matcher.sv
// Order: an accepted byte is registered, then processed when the stage advances;
//   a line result is then held in the result register and valid on rsp_.
// Throughput: one byte per cycle; the stage advances whenever the result
//   register is empty or being taken, so rsp_ready low stalls req_ready.
// Reset: synchronous active high; clears valids and the line state.
`default_nettype none
module serial_command_line_matcher
   import sclm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_rx_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [INDEX_W-1:0]        rsp_command_index,
   output logic                      rsp_recognised,
   output logic [LEN_OUT_W-1:0]      rsp_line_length
);

   logic                  s1_valid_ff, s1_valid_in;
   logic [7:0]            s1_byte_ff;
   logic [HELD_W-1:0]     held_ff, held_in;
   logic [TEXT_W-1:0]     text_len_ff, text_len_in;
   logic                  zero_seen_ff, zero_seen_in;
   logic [WORD_COUNT-1:0] alive_ff, alive_in;
   logic                  out_valid_ff, out_valid_in;
   match_type             out_pick_ff;
   logic [LEN_OUT_W-1:0]  out_len_ff;

   logic                  advance, process, is_term, emit;
   logic [WORD_COUNT-1:0] alive_upd;
   match_type             pick;
   logic [HELD_W+LEN_OUT_W-1:0] held_wide;

   sclm_match u_match (
      .alive     (alive_ff),
      .text_len  (text_len_ff),
      .rx_byte   (s1_byte_ff),
      .alive_upd (alive_upd),
      .pick      (pick)
   );

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign process   = s1_valid_ff && advance;
   assign is_term   = (s1_byte_ff == CHAR_LF) || (s1_byte_ff == CHAR_CR);
   assign emit      = process && is_term && (held_ff != '0);
   assign held_wide = {{LEN_OUT_W{1'b0}}, held_ff};

   always_comb begin
      s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
      out_valid_in = emit || (out_valid_ff && !rsp_ready);
      held_in      = held_ff;
      text_len_in  = text_len_ff;
      zero_seen_in = zero_seen_ff;
      alive_in     = alive_ff;
      if (process) begin
         if (is_term || held_ff == HELD_W'(LINE_CAPACITY - 1)) begin
            held_in      = '0;
            text_len_in  = '0;
            zero_seen_in = 1'b0;
            alive_in     = ALL_ALIVE;
         end else begin
            held_in = held_ff + 1'b1;
            if (!zero_seen_ff) begin
               if (s1_byte_ff == CHAR_NUL) begin
                  zero_seen_in = 1'b1;
               end else begin
                  alive_in = alive_upd;
                  if (text_len_ff != TEXT_W'(MAX_WORD_LEN + 1)) begin
                     text_len_in = text_len_ff + 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         held_ff      <= '0;
         text_len_ff  <= '0;
         zero_seen_ff <= 1'b0;
         alive_ff     <= ALL_ALIVE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         held_ff      <= held_in;
         text_len_ff  <= text_len_in;
         zero_seen_ff <= zero_seen_in;
         alive_ff     <= alive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_byte_ff <= req_rx_byte;
      end
      if (emit) begin
         out_pick_ff <= pick;
         out_len_ff  <= held_wide[LEN_OUT_W-1:0];
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_command_index = out_pick_ff.index;
   assign rsp_recognised    = out_pick_ff.recognised;
   assign rsp_line_length   = out_len_ff;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HELD_W'(LINE_CAPACITY - 1))
      else $error("line count beyond capacity");

   a_text_le_held: assert property (@(posedge clock) disable iff (reset)
      {{HELD_W{1'b0}}, text_len_ff} <= {{TEXT_W{1'b0}}, held_ff})
      else $error("text length exceeds held count");

   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_pick_ff.recognised) |-> (out_pick_ff.index == '0))
      else $error("index nonzero on unknown command");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> (out_len_ff != '0 || LINE_CAPACITY > 128))
      else $error("result for empty line");

   a_clear_after_term: assert property (@(posedge clock) disable iff (reset)
      (process && is_term) |=> (held_ff == '0 && alive_ff == ALL_ALIVE))
      else $error("line state not cleared after terminator");

endmodule
`default_nettype wire
